// File: design/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned DW            = 2 * OPERAND_WIDTH;
  localparam int unsigned CNT_W         = $clog2(DW + 1);

  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(1000000007);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_POW = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;

  typedef enum logic [1:0] {
    SRC_A,
    SRC_B,
    SRC_SUM,
    SRC_PROD
  } rem_src_e;

  typedef enum logic [1:0] {
    DST_X,
    DST_BASE,
    DST_ACC,
    DST_RES
  } rem_dst_e;

  typedef enum logic [1:0] {
    MUL_ACC_BASE,
    MUL_BASE_BASE,
    MUL_X_BASE,
    MUL_X_ACC
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     rem_start;
    rem_src_e rem_src;
    rem_dst_e rem_dst;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     pow_init;
    logic     expo_mod;
    logic     shift_expo;
    logic     sub_calc;
    logic     clear_res;
    logic     acc_to_res;
  } mau_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic a_zero;
    logic b_zero;
    logic m_zero;
    logic m_lt2;
    logic expo_zero;
    logic expo_lsb;
    logic expo_last;
  } mau_sts_t;

endpackage

// File: design/mau_rem.sv
// ----------------------------------------------------------------------------
// mau_rem
// Bit-serial restoring remainder unit: reduces a double-width value modulo
// the modulus, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mau_rem
  import mau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            dividend_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [OPERAND_WIDTH-1:0] rem_o
);

  logic [DW-1:0]            num_q, num_d;
  logic [OPERAND_WIDTH-1:0] r_q, r_d;
  logic [OPERAND_WIDTH-1:0] m_q, m_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [OPERAND_WIDTH:0]   trial;

  assign trial = {r_q, num_q[DW-1]};

  always_comb begin
    num_d  = num_q;
    r_d    = r_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      r_d    = '0;
      m_d    = modulus_i;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one bit, subtract when it fits
      if (trial >= {1'b0, m_q}) begin
        r_d = OPERAND_WIDTH'(trial - {1'b0, m_q});
      end else begin
        r_d = trial[OPERAND_WIDTH-1:0];
      end
      num_d = {num_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    r_q   <= r_d;
    m_q   <= m_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = r_q;

  a_start_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit started while busy");

  a_result_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < m_q))
    else $error("remainder not below modulus");

endmodule

// File: design/mau_datapath.sv
// ----------------------------------------------------------------------------
// mau_datapath
// Operand, modulus and working registers, the multiplier and the remainder
// unit, driven by commands from the controller.
// ----------------------------------------------------------------------------
module mau_datapath
  import mau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [FIELD_W-1:0] operand_a_i,
  input  logic [FIELD_W-1:0] operand_b_i,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_data_i,
  input  mau_cmd_t           cmd_i,
  output mau_sts_t           sts_o,
  output logic [FIELD_W-1:0] result_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [FIELD_W-1:0] mod_q;
  logic [W-1:0]       m;
  logic [W-1:0]       a_q, b_q, x_q, base_q, acc_q, expo_q, res_q;
  logic [DW-1:0]      prod_q;
  rem_dst_e           dst_q;
  logic [DW-1:0]      dividend;
  logic [W:0]         sum;
  logic [W-1:0]       mul_l, mul_r;
  logic [W-1:0]       rem;
  logic               rem_done;
  logic               rem_busy;

  assign m   = mod_q[W-1:0];
  assign sum = {1'b0, a_q} + {1'b0, b_q};

  always_comb begin
    unique case (cmd_i.rem_src)
      SRC_A:   dividend = DW'(a_q);
      SRC_B:   dividend = DW'(b_q);
      SRC_SUM: dividend = DW'(sum);
      default: dividend = prod_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_ACC_BASE:  begin mul_l = acc_q;  mul_r = base_q; end
      MUL_BASE_BASE: begin mul_l = base_q; mul_r = base_q; end
      MUL_X_BASE:    begin mul_l = x_q;    mul_r = base_q; end
      default:       begin mul_l = x_q;    mul_r = acc_q;  end
    endcase
  end

  mau_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (dividend),
    .modulus_i  (m),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= operand_a_i[W-1:0];
      b_q <= operand_b_i[W-1:0];
    end
    if (cmd_i.rem_start) begin
      dst_q <= cmd_i.rem_dst;
    end
    if (cmd_i.mul_en) begin
      prod_q <= DW'(mul_l) * DW'(mul_r);
    end
    if (cmd_i.pow_init) begin
      acc_q  <= (m == W'(1)) ? '0 : W'(1);
      expo_q <= cmd_i.expo_mod ? (m - W'(2)) : b_q;
    end else if (cmd_i.shift_expo) begin
      expo_q <= expo_q >> 1;
    end
    if (rem_done) begin
      unique case (dst_q)
        DST_X:    x_q    <= rem;
        DST_BASE: base_q <= rem;
        DST_ACC:  acc_q  <= rem;
        default:  res_q  <= rem;
      endcase
    end
    if (cmd_i.sub_calc) begin
      res_q <= (x_q - base_q) + ((x_q < base_q) ? m : '0);
    end else if (cmd_i.clear_res) begin
      res_q <= '0;
    end else if (cmd_i.acc_to_res) begin
      res_q <= acc_q;
    end
  end

  assign sts_o.rem_done  = rem_done;
  assign sts_o.a_zero    = (a_q == '0);
  assign sts_o.b_zero    = (b_q == '0);
  assign sts_o.m_zero    = (m == '0);
  assign sts_o.m_lt2     = (m < W'(2));
  assign sts_o.expo_zero = (expo_q == '0);
  assign sts_o.expo_lsb  = expo_q[0];
  assign sts_o.expo_last = (expo_q[W-1:1] == '0);

  assign result_o = FIELD_W'(res_q);

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rem_start && rem_busy) |-> 1'b0)
    else $error("reduction requested while remainder unit busy");

endmodule

// File: design/mau_ctrl.sv
// ----------------------------------------------------------------------------
// mau_ctrl
// Sequencer for the modular arithmetic unit: issues reductions, multiplies
// and the square-and-multiply loop to the datapath.
// ----------------------------------------------------------------------------
module mau_ctrl
  import mau_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] operation_i,
  input  mau_sts_t        sts_i,
  output mau_cmd_t        cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_WX    = 4'd2;
  localparam logic [3:0] S_WB2   = 4'd3;
  localparam logic [3:0] S_SUB   = 4'd4;
  localparam logic [3:0] S_MULX  = 4'd5;
  localparam logic [3:0] S_RPROD = 4'd6;
  localparam logic [3:0] S_WRES  = 4'd7;
  localparam logic [3:0] S_WBASE = 4'd8;
  localparam logic [3:0] S_PLOOP = 4'd9;
  localparam logic [3:0] S_RACC  = 4'd10;
  localparam logic [3:0] S_WACC  = 4'd11;
  localparam logic [3:0] S_SQ    = 4'd12;
  localparam logic [3:0] S_RSQ   = 4'd13;
  localparam logic [3:0] S_WSQ   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]      state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          op_d       = operation_i;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts_i.m_zero) begin
          cmd_o.clear_res = 1'b1;
          state_d         = S_OUT;
        end else if (op_q == OP_ADD) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_src   = SRC_SUM;
          cmd_o.rem_dst   = DST_RES;
          state_d         = S_WRES;
        end else if (op_q == OP_SUB || op_q == OP_MUL) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_src   = SRC_A;
          cmd_o.rem_dst   = DST_X;
          state_d         = S_WX;
        end else if (op_q == OP_POW) begin
          if (sts_i.a_zero) begin
            cmd_o.clear_res = 1'b1;
            state_d         = S_OUT;
          end else begin
            cmd_o.rem_start = 1'b1;
            cmd_o.rem_src   = SRC_A;
            cmd_o.rem_dst   = DST_BASE;
            cmd_o.pow_init  = 1'b1;
            state_d         = S_WBASE;
          end
        end else if (op_q == OP_DIV) begin
          if (sts_i.m_lt2 || sts_i.b_zero) begin
            cmd_o.clear_res = 1'b1;
            state_d         = S_OUT;
          end else begin
            cmd_o.rem_start = 1'b1;
            cmd_o.rem_src   = SRC_A;
            cmd_o.rem_dst   = DST_X;
            state_d         = S_WX;
          end
        end else begin
          cmd_o.clear_res = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_WX: begin
        if (sts_i.rem_done) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_src   = SRC_B;
          cmd_o.rem_dst   = DST_BASE;
          cmd_o.pow_init  = 1'b1;
          cmd_o.expo_mod  = 1'b1;
          state_d         = (op_q == OP_DIV) ? S_WBASE : S_WB2;
        end
      end
      S_WB2: begin
        if (sts_i.rem_done) begin
          state_d = (op_q == OP_SUB) ? S_SUB : S_MULX;
        end
      end
      S_SUB: begin
        cmd_o.sub_calc = 1'b1;
        state_d        = S_OUT;
      end
      S_MULX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = (op_q == OP_DIV) ? MUL_X_ACC : MUL_X_BASE;
        state_d       = S_RPROD;
      end
      S_RPROD: begin
        cmd_o.rem_start = 1'b1;
        cmd_o.rem_src   = SRC_PROD;
        cmd_o.rem_dst   = DST_RES;
        state_d         = S_WRES;
      end
      S_WRES: begin
        if (sts_i.rem_done) begin
          state_d = S_OUT;
        end
      end
      S_WBASE: begin
        if (sts_i.rem_done) begin
          state_d = S_PLOOP;
        end
      end
      S_PLOOP: begin
        priority if (sts_i.expo_zero) begin
          if (op_q == OP_DIV) begin
            state_d = S_MULX;
          end else begin
            cmd_o.acc_to_res = 1'b1;
            state_d          = S_OUT;
          end
        end else if (sts_i.expo_lsb) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_ACC_BASE;
          state_d       = S_RACC;
        end else begin
          state_d = S_SQ;
        end
      end
      S_RACC: begin
        cmd_o.rem_start = 1'b1;
        cmd_o.rem_src   = SRC_PROD;
        cmd_o.rem_dst   = DST_ACC;
        state_d         = S_WACC;
      end
      S_WACC: begin
        if (sts_i.rem_done) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.shift_expo = 1'b1;
        if (sts_i.expo_last) begin
          // last exponent bit, square not needed
          state_d = S_PLOOP;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_BASE_BASE;
          state_d       = S_RSQ;
        end
      end
      S_RSQ: begin
        cmd_o.rem_start = 1'b1;
        cmd_o.rem_src   = SRC_PROD;
        cmd_o.rem_dst   = DST_BASE;
        state_d         = S_WSQ;
      end
      S_WSQ: begin
        if (sts_i.rem_done) begin
          state_d = S_PLOOP;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_accept_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_DISP) && (op_q == $past(operation_i)))
    else $error("accepted transaction not dispatched");

endmodule

// File: design/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, power and Fermat-inverse divide modulo a
// configurable modulus.
// ----------------------------------------------------------------------------
// Usage: drive operation_i, operand_a_i and operand_b_i and raise start_i;
// the transaction is taken at a clock edge where start_i is high and busy_o
// is low. busy_o stays high until the result has been shown. The result is
// on result_o for exactly one cycle with done_o high; the receiver cannot
// stall it, so it must take it in that cycle.
// The modulus is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
// cfg_ready_o is high only while the unit is idle.
// Reductions are done by the bit-serial remainder unit, which takes one
// dividend bit per cycle. Zero modulus, zero power base, zero divisor,
// divide with a modulus below 2 and unused codes finish without a
// reduction and give zero. busy_o drops in the cycle after done_o, so one
// transaction is in flight at a time.
// Reset restores the modulus to 1000000007 and returns the unit to idle.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
  import mau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [FIELD_W-1:0] operand_a_i,
  input  logic [FIELD_W-1:0] operand_b_i,
  output logic               done_o,
  output logic [FIELD_W-1:0] result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FIELD_W-1:0] cfg_data_i
);

  mau_cmd_t cmd;
  mau_sts_t sts;
  logic     busy;

  assign busy_o      = busy;
  assign cfg_ready_o = !busy;

  mau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .done_o      (done_o)
  );

  mau_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cfg_we_i    (cfg_valid_i && !busy),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule
